// ----- sv/wbs_pkg.sv -----
// Package for the word-break segmenter: mode codes, default sizes and the
// dictionary command struct. Depends on nothing.
package wbs_pkg;

  localparam int DICT_WORDS_DEF   = 16;
  localparam int MAX_WORD_LEN_DEF = 16;
  localparam int MODE_W           = 2;
  localparam int SYMBOL_W         = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_DICT  = 2'd1,
    MODE_TEXT  = 2'd2
  } mode_t;

  typedef struct packed {
    logic                clear;
    logic                load;
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
  } dict_cmd_t;

endpackage

// ----- sv/wbs_if.sv -----
// Valid/ready channels of the word-break segmenter: input items and results.
// Depends on wbs_pkg for field widths.
interface wbs_in_if import wbs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [SYMBOL_W-1:0] symbol;
  logic                last;

  modport source (output valid, output mode, output symbol, output last, input ready);
  modport sink (input valid, input mode, input symbol, input last, output ready);
endinterface

interface wbs_out_if import wbs_pkg::*; ();
  logic valid;
  logic ready;
  logic segmentable;
  logic dictionary_overflow;

  modport source (output valid, output segmentable, output dictionary_overflow, input ready);
  modport sink (input valid, input segmentable, input dictionary_overflow, output ready);
endinterface

// ----- sv/wbs_dict.sv -----
// Dictionary store of the word-break segmenter: word bytes, lengths, load
// sequencing and the overflow flag. Depends on wbs_pkg.
module wbs_dict import wbs_pkg::*; #(
  parameter int DICT_WORDS   = DICT_WORDS_DEF,
  parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF,
  localparam int LEN_W       = $clog2(MAX_WORD_LEN + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  dict_cmd_t           cmd,
  output logic [SYMBOL_W-1:0] chars [DICT_WORDS][MAX_WORD_LEN],
  output logic [LEN_W-1:0]    lengths [DICT_WORDS],
  output logic                overflow
);

  localparam int CNT_W  = $clog2(DICT_WORDS + 1);
  localparam int WIDX_W = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
  localparam int CIDX_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

  logic [CNT_W-1:0] count, count_next;
  logic [LEN_W-1:0] fill, fill_next, fill_after;
  logic             dropped, dropped_next, drop_after;
  logic             overflow_next;
  logic             wr_char, wr_len;

  always_comb begin
    count_next    = count;
    fill_next     = fill;
    dropped_next  = dropped;
    overflow_next = overflow;
    wr_char       = 1'b0;
    wr_len        = 1'b0;
    fill_after    = fill;
    drop_after    = dropped;
    if (cmd.clear) begin
      count_next    = '0;
      fill_next     = '0;
      dropped_next  = 1'b0;
      overflow_next = 1'b0;
    end else if (cmd.load) begin
      if (count == CNT_W'(DICT_WORDS)) begin
        overflow_next = 1'b1;
        fill_next     = '0;
        dropped_next  = 1'b0;
      end else begin
        if (!dropped) begin
          if (fill < LEN_W'(MAX_WORD_LEN)) begin
            wr_char    = 1'b1;
            fill_after = fill + LEN_W'(1);
          end else begin
            drop_after    = 1'b1;
            overflow_next = 1'b1;
          end
        end
        fill_next    = fill_after;
        dropped_next = drop_after;
        if (cmd.last) begin
          if (!drop_after && fill_after != '0) begin
            wr_len     = 1'b1;
            count_next = count + CNT_W'(1);
          end
          fill_next    = '0;
          dropped_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      fill     <= '0;
      dropped  <= 1'b0;
      overflow <= 1'b0;
    end else begin
      count    <= count_next;
      fill     <= fill_next;
      dropped  <= dropped_next;
      overflow <= overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int w = 0; w < DICT_WORDS; w++) lengths[w] <= '0;
    end else if (wr_len) begin
      lengths[count[WIDX_W-1:0]] <= fill_after;
    end
  end

  // Word bytes need no reset: only bytes of committed words are ever matched.
  always_ff @(posedge clk) begin
    if (wr_char) begin
      chars[count[WIDX_W-1:0]][fill[CIDX_W-1:0]] <= cmd.symbol;
    end
  end

endmodule

// ----- sv/wbs_match.sv -----
// Parallel backward match of every stored word against the newest text bytes.
// Depends on wbs_pkg.
module wbs_match import wbs_pkg::*; #(
  parameter int DICT_WORDS   = DICT_WORDS_DEF,
  parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF,
  localparam int LEN_W       = $clog2(MAX_WORD_LEN + 1)
) (
  input  logic [SYMBOL_W-1:0] chars [DICT_WORDS][MAX_WORD_LEN],
  input  logic [LEN_W-1:0]    lengths [DICT_WORDS],
  input  logic [SYMBOL_W-1:0] hist [MAX_WORD_LEN],
  input  logic [MAX_WORD_LEN:0] reach,
  output logic                hit
);

  localparam int CIDX_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

  logic [DICT_WORDS-1:0] word_ok;
  logic [LEN_W-1:0]      pos, rpos;

  always_comb begin
    pos  = '0;
    rpos = '0;
    for (int w = 0; w < DICT_WORDS; w++) begin
      rpos       = lengths[w] - LEN_W'(1);
      word_ok[w] = (lengths[w] != '0) && reach[rpos];
      for (int i = 0; i < MAX_WORD_LEN; i++) begin
        if (LEN_W'(i) < lengths[w]) begin
          // byte i of the word lines up with the byte (length-1-i) back
          pos = lengths[w] - LEN_W'(i) - LEN_W'(1);
          if (chars[w][i] != hist[pos[CIDX_W-1:0]]) word_ok[w] = 1'b0;
        end
      end
    end
    hit = |word_ok;
  end

endmodule

// ----- sv/word_break_segmenter.sv -----
// Top level of the word-break segmenter with its input and result registers.
// Depends on wbs_pkg, wbs_if, wbs_dict and wbs_match.
//
// Decides whether a streamed text splits into words of a loadable
// dictionary. Items carry a mode: clear empties the dictionary and clears the
// overflow flag, dictionary bytes load words (last ends a word), text bytes
// run the match (last ends the text and yields one result transaction with
// segmentable and dictionary_overflow). Words beyond DICT_WORDS, or longer
// than MAX_WORD_LEN bytes, are dropped whole and raise dictionary_overflow.
// Throughput is one item per clock cycle while the input register is not
// holding an item: every stored word is compared at once against a shift
// register of the last MAX_WORD_LEN text bytes, and a reachability vector
// of MAX_WORD_LEN+1 bits carries the prefix history. A result is loaded into
// the result register from the input register and held there until taken.
// The input register holds an item only when it would produce a result
// while the result register is still full and not being taken; otherwise it
// advances every cycle. No clearing pass is needed after reset.
module word_break_segmenter import wbs_pkg::*; #(
  parameter int DICT_WORDS   = DICT_WORDS_DEF,
  parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
  input logic      clk,
  input logic      rst,
  wbs_in_if.sink   items,
  wbs_out_if.source results
);

  localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);

  // Input register
  logic                s1_valid;
  logic [MODE_W-1:0]   s1_mode;
  logic [SYMBOL_W-1:0] s1_symbol;
  logic                s1_last;

  // Text history: index 0 newest; reach bit k is the prefix that ended k bytes ago
  logic [SYMBOL_W-1:0]   text_history [MAX_WORD_LEN];
  logic [SYMBOL_W-1:0]   hist_new [MAX_WORD_LEN];
  logic [MAX_WORD_LEN:0] reach;

  // Result register
  logic out_valid;
  logic out_seg;
  logic out_ovf;

  logic [SYMBOL_W-1:0] chars [DICT_WORDS][MAX_WORD_LEN];
  logic [LEN_W-1:0]    lengths [DICT_WORDS];
  logic                overflow;
  logic                hit;
  logic                s1_result, advance, is_text;
  dict_cmd_t           cmd;

  // Only a text-ending byte needs the result register; hold it while that is full and not being taken.
  assign is_text   = (s1_mode == MODE_TEXT);
  assign s1_result = s1_valid && is_text && s1_last;
  assign advance   = s1_valid && (!s1_result || !out_valid || results.ready);
  assign items.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.valid && items.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s1_mode   <= items.mode;
      s1_symbol <= items.symbol;
      s1_last   <= items.last;
    end
  end

  // Dictionary commands are issued only when the input register advances.
  always_comb begin
    cmd.clear  = 1'b0;
    cmd.load   = 1'b0;
    cmd.symbol = s1_symbol;
    cmd.last   = s1_last;
    case (s1_mode)
      MODE_CLEAR: cmd.clear = advance;
      MODE_DICT:  cmd.load  = advance;
      default:    ;
    endcase
  end

  wbs_dict #(
    .DICT_WORDS   (DICT_WORDS),
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_dict (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .chars    (chars),
    .lengths  (lengths),
    .overflow (overflow)
  );

  // Shift the new byte in front of the stored history for the match.
  always_comb begin
    hist_new[0] = s1_symbol;
    for (int k = 1; k < MAX_WORD_LEN; k++) hist_new[k] = text_history[k-1];
  end

  wbs_match #(
    .DICT_WORDS   (DICT_WORDS),
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_match (
    .chars   (chars),
    .lengths (lengths),
    .hist    (hist_new),
    .reach   (reach),
    .hit     (hit)
  );

  // Advance the history on every text byte; drop it at the end of a text.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_WORD_LEN; k++) text_history[k] <= '0;
      reach <= (MAX_WORD_LEN + 1)'(1);
    end else if (advance && is_text) begin
      if (s1_last) begin
        for (int k = 0; k < MAX_WORD_LEN; k++) text_history[k] <= '0;
        reach <= (MAX_WORD_LEN + 1)'(1);
      end else begin
        for (int k = 0; k < MAX_WORD_LEN; k++) text_history[k] <= hist_new[k];
        reach <= {reach[MAX_WORD_LEN-1:0], hit};
      end
    end
  end

  // Result register: load on a text ending, empty when the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_result) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_result) begin
      out_seg <= hit;
      out_ovf <= overflow;
    end
  end

  assign results.valid               = out_valid;
  assign results.segmentable         = out_seg;
  assign results.dictionary_overflow = out_ovf;

endmodule
